FILE: design/mbps_pkg.sv
// ----------------------------------------------------------------------------
// Masked byte pattern search package
// Register indexes, configuration widths and the pattern setup record that
// the front end uses to compare the window against the pattern.
// ----------------------------------------------------------------------------
`default_nettype none

package mbps_pkg;

  localparam int CFG_INDEX_W   = 3;
  localparam int CFG_DATA_W    = 64;
  localparam int PATTERN_BYTES = 32;
  localparam int LENGTH_W      = 6;
  localparam int ADDRESS_W     = 64;
  localparam int RESULT_OFF_W  = 32;
  localparam int QUEUE_DEPTH   = 2;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_PATTERN_LENGTH = 3'd0,
    REG_PATTERN_WORD_0 = 3'd1,
    REG_PATTERN_WORD_1 = 3'd2,
    REG_PATTERN_WORD_2 = 3'd3,
    REG_PATTERN_WORD_3 = 3'd4,
    REG_CARE_MASK      = 3'd5,
    REG_BASE_ADDRESS   = 3'd6
  } cfg_reg_t;

  // Pattern setup as seen by the front end.
  typedef struct packed {
    logic [LENGTH_W-1:0]          pattern_length;
    logic [PATTERN_BYTES-1:0]     care_mask;
    logic [8*PATTERN_BYTES-1:0]   pattern_bytes;
  } match_cfg_t;

endpackage

`default_nettype wire

FILE: design/mbps_if.sv
// ----------------------------------------------------------------------------
// Masked byte pattern search channels
// Valid/ready channels for region bytes and for search results.
// ----------------------------------------------------------------------------
`default_nettype none

interface mbps_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface mbps_out_if;
  logic        valid;
  logic        ready;
  logic        found;
  logic [31:0] match_offset;
  logic [63:0] match_address;

  modport source (output valid, output found, output match_offset, output match_address,
                  input ready);
  modport sink   (input valid, input found, input match_offset, input match_address,
                  output ready);
endinterface

`default_nettype wire

FILE: design/mbps_front.sv
// ----------------------------------------------------------------------------
// Masked byte pattern search front end
// Shifts region bytes into the window, compares the window ending at the
// newest byte with the pattern and records the first match of the region.
// ----------------------------------------------------------------------------
`default_nettype none

module mbps_front #(
  parameter int PATTERN_MAX = 32,
  parameter int OFFSET_BITS = 32
) (
  input  wire                      clk,
  input  wire                      rst_n,
  mbps_in_if.sink                  in_ch,
  input  wire mbps_pkg::match_cfg_t cfg,
  input  wire                      q_full,
  output logic                     q_push,
  output logic [OFFSET_BITS:0]     q_push_data
);
  import mbps_pkg::*;

  localparam int NW = $clog2(PATTERN_MAX + 1);
  localparam int IW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
  localparam int PK = (PATTERN_MAX < PATTERN_BYTES) ? PATTERN_MAX : PATTERN_BYTES;

  logic [7:0]             win_r [PATTERN_MAX];
  logic [7:0]             win_nxt [PATTERN_MAX];
  logic [OFFSET_BITS-1:0] seen_r, seen_nxt;
  logic                   match_r, match_nxt;
  logic [OFFSET_BITS-1:0] first_r, first_nxt;

  logic [NW-1:0]          act_len;
  logic                   window_hit;
  logic                   new_hit;
  logic                   accept;
  logic [OFFSET_BITS-1:0] count;
  logic [OFFSET_BITS-1:0] hit_offset;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;

  // Active length: zero counts as one, long patterns saturate.
  always_comb begin
    if (cfg.pattern_length == '0) begin
      act_len = NW'(1);
    end else if (int'(cfg.pattern_length) > PATTERN_MAX) begin
      act_len = NW'(PATTERN_MAX);
    end else begin
      act_len = NW'(cfg.pattern_length);
    end
  end

  always_comb begin
    win_nxt[0] = in_ch.data_byte;
    for (int j = 1; j < PATTERN_MAX; j++) begin
      win_nxt[j] = win_r[j-1];
    end
  end

  // Pattern byte k lines up with window entry act_len-1-k. Bytes past the
  // configurable pattern storage are always wildcards.
  always_comb begin
    int         len_i;
    logic [IW-1:0] idx;
    len_i      = int'(act_len);
    window_hit = 1'b1;
    idx        = '0;
    for (int k = 0; k < PK; k++) begin
      idx = IW'(len_i - 1 - k);
      if (k < len_i && cfg.care_mask[k] &&
          win_nxt[idx] != cfg.pattern_bytes[8*k +: 8]) begin
        window_hit = 1'b0;
      end
    end
  end

  assign count      = seen_r + OFFSET_BITS'(1);
  assign hit_offset = count - OFFSET_BITS'(act_len);
  assign new_hit    = !(&seen_r) && !match_r &&
                      (count >= OFFSET_BITS'(act_len)) && window_hit;

  always_comb begin
    seen_nxt  = seen_r;
    match_nxt = match_r;
    first_nxt = first_r;
    if (accept) begin
      if (in_ch.last_byte) begin
        seen_nxt  = '0;
        match_nxt = 1'b0;
        first_nxt = '0;
      end else begin
        if (!(&seen_r)) begin
          seen_nxt = count;
        end
        if (new_hit) begin
          match_nxt = 1'b1;
          first_nxt = hit_offset;
        end
      end
    end
  end

  assign q_push      = accept && in_ch.last_byte;
  assign q_push_data = {match_r || new_hit, new_hit ? hit_offset : first_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r  <= '0;
      match_r <= 1'b0;
      first_r <= '0;
    end else begin
      seen_r  <= seen_nxt;
      match_r <= match_nxt;
      first_r <= first_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      win_r <= win_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: design/mbps_queue.sv
// ----------------------------------------------------------------------------
// Masked byte pattern search result queue
// Short first-in first-out queue between the front end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module mbps_queue #(
  parameter int WIDTH = 33
) (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              push,
  input  wire [WIDTH-1:0]  push_data,
  input  wire              pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             full,
  output logic             empty
);
  import mbps_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0] mem_r [QUEUE_DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;

  assign full     = (cnt_r == CW'(QUEUE_DEPTH));
  assign empty    = (cnt_r == '0);
  assign pop_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

FILE: design/mbps_back.sv
// ----------------------------------------------------------------------------
// Masked byte pattern search back end
// Takes a finished region from the queue, forms the match address and holds
// the result in the output register until the receiver takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module mbps_back #(
  parameter int OFFSET_BITS = 32
) (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire [mbps_pkg::ADDRESS_W-1:0]      base_address,
  input  wire                                q_empty,
  input  wire [OFFSET_BITS:0]                q_pop_data,
  output logic                               q_pop,
  mbps_out_if.source                         out_ch
);
  import mbps_pkg::*;

  logic                    valid_r, valid_nxt;
  logic                    found_r;
  logic [RESULT_OFF_W-1:0] offset_r;
  logic [ADDRESS_W-1:0]    address_r;
  logic                    rec_found;
  logic [OFFSET_BITS-1:0]  rec_offset;

  assign rec_found  = q_pop_data[OFFSET_BITS];
  assign rec_offset = q_pop_data[OFFSET_BITS-1:0];

  // The output register reloads whenever it is empty or being drained.
  assign q_pop = !q_empty && (!valid_r || out_ch.ready);

  always_comb begin
    valid_nxt = valid_r;
    if (q_pop) begin
      valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      found_r <= rec_found;
      if (rec_found) begin
        offset_r  <= RESULT_OFF_W'(rec_offset);
        address_r <= base_address + ADDRESS_W'(rec_offset);
      end else begin
        offset_r  <= '0;
        address_r <= '0;
      end
    end
  end

  assign out_ch.valid         = valid_r;
  assign out_ch.found         = found_r;
  assign out_ch.match_offset  = offset_r;
  assign out_ch.match_address = address_r;

endmodule

`default_nettype wire

FILE: design/masked_byte_pattern_search.sv
// ----------------------------------------------------------------------------
// Masked byte pattern search
// Streaming search of a byte region for the first window that matches a
// configured pattern with per-byte wildcards.
// ----------------------------------------------------------------------------
// Usage:
//   The region arrives on in_ch, one byte per request, in address order;
//   last_byte marks its final byte. Each byte closes the window that ends
//   at it, and that window is compared with the pattern in the same cycle.
//   The first match of the region is remembered. Only the last byte of a
//   region causes a result, delivered on out_ch: found, the window start
//   offset and base_address plus that offset (both zero without a match).
//   The block takes one byte per cycle, back to back, while the queue is
//   not full. out_ch.valid rises after the last byte is taken: the front
//   end pushes the result into a two-entry queue, and the back end pops it
//   and forms the address in its output register. If the receiver stalls,
//   the output register holds its result and the queue absorbs two more
//   regions; in_ch.ready falls only when the queue is full. Reset returns
//   the registers to their defaults and empties the scan state, queue and
//   output register; no clearing pass is needed. Registers are written
//   through cfg_we, cfg_index and cfg_data. The user must write them only
//   while no region is in progress and no result is pending; the block
//   itself does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module masked_byte_pattern_search #(
  parameter int PATTERN_MAX = 32,
  parameter int OFFSET_BITS = 32
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  mbps_in_if.sink                             in_ch,
  mbps_out_if.source                          out_ch,
  input  wire                                 cfg_we,
  input  wire [mbps_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  wire [mbps_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import mbps_pkg::*;

  // Configuration registers.
  logic [LENGTH_W-1:0]        pattern_length_r;
  logic [8*PATTERN_BYTES-1:0] pattern_bytes_r;
  logic [PATTERN_BYTES-1:0]   care_mask_r;
  logic [ADDRESS_W-1:0]       base_address_r;
  match_cfg_t                 match_cfg;

  // Queue connections between the front end and the back end.
  logic                   q_push;
  logic [OFFSET_BITS:0]   q_push_data;
  logic                   q_pop;
  logic [OFFSET_BITS:0]   q_pop_data;
  logic                   q_full;
  logic                   q_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_length_r <= LENGTH_W'(1);
      pattern_bytes_r  <= '0;
      care_mask_r      <= '0;
      base_address_r   <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_PATTERN_LENGTH: pattern_length_r <= cfg_data[LENGTH_W-1:0];
        REG_PATTERN_WORD_0: pattern_bytes_r[63:0]    <= cfg_data;
        REG_PATTERN_WORD_1: pattern_bytes_r[127:64]  <= cfg_data;
        REG_PATTERN_WORD_2: pattern_bytes_r[191:128] <= cfg_data;
        REG_PATTERN_WORD_3: pattern_bytes_r[255:192] <= cfg_data;
        REG_CARE_MASK:      care_mask_r <= cfg_data[PATTERN_BYTES-1:0];
        REG_BASE_ADDRESS:   base_address_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign match_cfg.pattern_length = pattern_length_r;
  assign match_cfg.care_mask      = care_mask_r;
  assign match_cfg.pattern_bytes  = pattern_bytes_r;

  mbps_front #(
    .PATTERN_MAX (PATTERN_MAX),
    .OFFSET_BITS (OFFSET_BITS)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .cfg         (match_cfg),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_push_data (q_push_data)
  );

  mbps_queue #(
    .WIDTH (OFFSET_BITS + 1)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .pop       (q_pop),
    .pop_data  (q_pop_data),
    .full      (q_full),
    .empty     (q_empty)
  );

  mbps_back #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .base_address (base_address_r),
    .q_empty      (q_empty),
    .q_pop_data   (q_pop_data),
    .q_pop        (q_pop),
    .out_ch       (out_ch)
  );

endmodule

`default_nettype wire

FILE: design/mbps_checker.sv
// ----------------------------------------------------------------------------
// Masked byte pattern search port checker
// Watches the top level ports and flags results that break the block's
// guarantees.
// ----------------------------------------------------------------------------
`default_nettype none

module mbps_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        in_ready,
  input wire        out_valid,
  input wire        out_ready,
  input wire        out_found,
  input wire [31:0] out_match_offset,
  input wire [63:0] out_match_address
);

  // A stalled result keeps its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_found) &&
      $stable(out_match_offset) && $stable(out_match_address))
    else $error("result changed while stalled");

  // A region without a match reports zero offset and address.
  a_no_match_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_match_offset == 32'd0 && out_match_address == 64'd0)
    else $error("no-match result carries nonzero fields");

  // The input side only backs up behind a pending result.
  a_ready_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with no result pending");

  // Reset empties the output register.
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind masked_byte_pattern_search mbps_checker u_mbps_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_ready          (in_ch.ready),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_found         (out_ch.found),
  .out_match_offset  (out_ch.match_offset),
  .out_match_address (out_ch.match_address)
);

`default_nettype wire

FILE: dv/tb_top.sv
// ----------------------------------------------------------------------------
// Masked byte pattern search testbench
// Sends byte regions through the input channel and checks every search
// result against a scan model kept inside this bench. A short walk through
// fixed cases comes first: reset defaults, address wrap, short regions and
// out-of-range lengths. Random phases follow. Each phase picks a new pattern
// setup and sends regions that mostly hold a planted copy of the pattern.
// Some of those copies are slightly spoiled. Both channels idle at random.
// ----------------------------------------------------------------------------
module tb_top;
  import mbps_pkg::*;

  localparam int RANDOM_BYTES  = 1875;
  localparam int SETTLE_CYCLES = 4;
  localparam int DRAIN_CYCLES  = 20;
  localparam int QUIET_LIMIT   = 2000;
  localparam int PLAN_ROWS     = 33;

  typedef struct packed {
    logic        found;
    logic [31:0] offset;
    logic [63:0] address;
  } search_result_t;

  typedef enum logic {STEP_REG_WRITE, STEP_BYTE} step_kind_t;

  // One row of the directed walk. A register write uses reg_sel and value.
  // A byte uses data and last. When typed is set, the row's result fields
  // replace the scan model's result for that region.
  typedef struct packed {
    step_kind_t  kind;
    cfg_reg_t    reg_sel;
    logic [63:0] value;
    logic [7:0]  data;
    logic        last;
    logic        typed;
    logic        exp_found;
    logic [31:0] exp_offset;
    logic [63:0] exp_address;
  } plan_step_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  mbps_in_if  in_ch ();
  mbps_out_if out_ch ();

  masked_byte_pattern_search i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Shadow copy of the pattern registers, at their reset values.
  logic [5:0]  pat_len        = 6'd1;
  logic [63:0] pat_words [4]  = '{default: '0};
  logic [31:0] care_bits      = '0;
  logic [63:0] base_addr      = '0;

  // Scan state of the model. win[0] holds the newest byte.
  logic [7:0]  win [PATTERN_BYTES] = '{default: '0};
  logic [31:0] seen_bytes = '0;
  logic        hit_seen   = 1'b0;
  logic [31:0] hit_offset = '0;

  search_result_t pending_searches [$];
  int mismatch_count = 0;
  int random_bytes   = 0;
  int quiet_cycles   = 0;
  bit in_idle_on     = 1'b1;
  bit out_idle_on    = 1'b1;

  // The directed row on the input channel carries its own result, if any.
  bit             plan_typed  = 1'b0;
  search_result_t plan_result = '0;

  // Register changes happen only between regions, so the walk here mixes
  // register writes with bytes. Typed rows are the ones whose result is
  // obvious. Address wrap, the reset defaults and short regions are among
  // them. The rest is left to the scan model.
  plan_step_t directed_plan [PLAN_ROWS] = '{
    // Reset setup: length 1, all wildcards, so any byte matches at 0.
    '{STEP_BYTE, REG_PATTERN_LENGTH, 64'h0, 8'h00, 1'b1, 1'b1, 1'b1, 32'd0, 64'h0},
    '{STEP_REG_WRITE, REG_BASE_ADDRESS, 64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 1'b0, 1'b0,
      1'b0, 32'd0, 64'h0},
    // A pattern length of zero acts as one.
    '{STEP_REG_WRITE, REG_PATTERN_LENGTH, 64'h0, 8'h00, 1'b0, 1'b0, 1'b0, 32'd0, 64'h0},
    '{STEP_BYTE, REG_PATTERN_LENGTH, 64'h0, 8'hFF, 1'b0, 1'b0, 1'b0, 32'd0, 64'h0},
    '{STEP_BYTE, REG_PATTERN_LENGTH, 64'h0, 8'h5A, 1'b1, 1'b1, 1'b1, 32'd0,
      64'hFFFF_FFFF_FFFF_FFFF},
    // Exact four byte pattern DE AD BE EF.
    '{STEP_REG_WRITE, REG_PATTERN_WORD_0, 64'h0000_0000_EFBE_ADDE, 8'h00, 1'b0, 1'b0,
      1'b0, 32'd0, 64'h0},
    '{STEP_REG_WRITE, REG_CARE_MASK, 64'hFFFF_FFFF, 8'h00, 1'b0, 1'b0, 1'b0, 32'd0, 64'h0},
    '{STEP_REG_WRITE, REG_PATTERN_LENGTH, 64'd4, 8'h00, 1'b0, 1'b0, 1'b0, 32'd0, 64'h0},
    // Match at offset one, so the address wraps around to zero.
    '{STEP_BYTE, REG_PATTERN_LENGTH, 64'h0, 8'h11, 1'b0, 1'b0, 1'b0, 32'd0, 64'h0},
    '{STEP_BYTE, REG_PATTERN_LENGTH, 64'h0, 8'hDE, 1'b0, 1'b0, 1'b0, 32'd0, 64'h0},
    '{STEP_BYTE, REG_PATTERN_LENGTH, 64'h0, 8'hAD, 1'b0, 1'b0, 1'b0, 32'd0, 64'h0},
    '{STEP_BYTE, REG_PATTERN_LENGTH, 64'h0, 8'hBE, 1'b0, 1'b0, 1'b0, 32'd0, 64'h0},
    '{STEP_BYTE, REG_PATTERN_LENGTH, 64'h0, 8'hEF, 1'b1, 1'b1, 1'b1, 32'd1, 64'h0},
    // A region shorter than the pattern never matches.
    '{STEP_BYTE, REG_PATTERN_LENGTH, 64'h0, 8'hDE, 1'b0, 1'b0, 1'b0, 32'd0, 64'h0},
    '{STEP_BYTE, REG_PATTERN_LENGTH, 64'h0, 8'hAD, 1'b1, 1'b1, 1'b0, 32'd0, 64'h0},
    // Near miss first, then the real match at offset four.
    '{STEP_BYTE, REG_PATTERN_LENGTH, 64'h0, 8'hDE, 1'b0, 1'b0, 1'b0, 32'd0, 64'h0},
    '{STEP_BYTE, REG_PATTERN_LENGTH, 64'h0, 8'hAD, 1'b0, 1'b0, 1'b0, 32'd0, 64'h0},
    '{STEP_BYTE, REG_PATTERN_LENGTH, 64'h0, 8'hBE, 1'b0, 1'b0, 1'b0, 32'd0, 64'h0},
    '{STEP_BYTE, REG_PATTERN_LENGTH, 64'h0, 8'hEE, 1'b0, 1'b0, 1'b0, 32'd0, 64'h0},
    '{STEP_BYTE, REG_PATTERN_LENGTH, 64'h0, 8'hDE, 1'b0, 1'b0, 1'b0, 32'd0, 64'h0},
    '{STEP_BYTE, REG_PATTERN_LENGTH, 64'h0, 8'hAD, 1'b0, 1'b0, 1'b0, 32'd0, 64'h0},
    '{STEP_BYTE, REG_PATTERN_LENGTH, 64'h0, 8'hBE, 1'b0, 1'b0, 1'b0, 32'd0, 64'h0},
    '{STEP_BYTE, REG_PATTERN_LENGTH, 64'h0, 8'hEF, 1'b1, 1'b0, 1'b0, 32'd0, 64'h0},
    // Only the outer bytes count: DE ?? ?? EF.
    '{STEP_REG_WRITE, REG_CARE_MASK, 64'h9, 8'h00, 1'b0, 1'b0, 1'b0, 32'd0, 64'h0},
    '{STEP_BYTE, REG_PATTERN_LENGTH, 64'h0, 8'hDE, 1'b0, 1'b0, 1'b0, 32'd0, 64'h0},
    '{STEP_BYTE, REG_PATTERN_LENGTH, 64'h0, 8'h00, 1'b0, 1'b0, 1'b0, 32'd0, 64'h0},
    '{STEP_BYTE, REG_PATTERN_LENGTH, 64'h0, 8'hFF, 1'b0, 1'b0, 1'b0, 32'd0, 64'h0},
    '{STEP_BYTE, REG_PATTERN_LENGTH, 64'h0, 8'hEF, 1'b0, 1'b0, 1'b0, 32'd0, 64'h0},
    '{STEP_BYTE, REG_PATTERN_LENGTH, 64'h0, 8'h80, 1'b1, 1'b0, 1'b0, 32'd0, 64'h0},
    // Oversized length saturates at 32, so a two byte region finds nothing.
    '{STEP_REG_WRITE, REG_PATTERN_LENGTH, 64'd63, 8'h00, 1'b0, 1'b0, 1'b0, 32'd0, 64'h0},
    '{STEP_REG_WRITE, REG_CARE_MASK, 64'h0, 8'h00, 1'b0, 1'b0, 1'b0, 32'd0, 64'h0},
    '{STEP_BYTE, REG_PATTERN_LENGTH, 64'h0, 8'h01, 1'b0, 1'b0, 1'b0, 32'd0, 64'h0},
    '{STEP_BYTE, REG_PATTERN_LENGTH, 64'h0, 8'h02, 1'b1, 1'b1, 1'b0, 32'd0, 64'h0}
  };

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Number of pattern bytes in use after the zero and saturation rules.
  function automatic int unsigned active_len();
    if (pat_len == 0) return 1;
    if (pat_len > PATTERN_BYTES) return PATTERN_BYTES;
    return pat_len;
  endfunction

  function automatic logic [7:0] pattern_byte(input int unsigned k);
    return pat_words[k / 8][8 * (k % 8) +: 8];
  endfunction

  // Takes one byte of the region into the scan model. Returns 1 when the byte
  // closes the region, with the search result in res.
  function automatic bit search_step(input logic [7:0] b, input logic is_last,
                                     output search_result_t res);
    int unsigned n;
    logic [31:0] count;
    bit hit;
    n = active_len();
    for (int i = PATTERN_BYTES - 1; i > 0; i--) win[i] = win[i - 1];
    win[0] = b;
    res = '0;
    // The byte count stops at its maximum. After that no window is tried.
    if (seen_bytes != 32'hFFFF_FFFF) begin
      count = seen_bytes + 1;
      if (!hit_seen && count >= n) begin
        hit = 1'b1;
        // The oldest byte of the window lines up with pattern byte 0.
        for (int unsigned k = 0; k < n; k++) begin
          if (care_bits[k] && win[n - 1 - k] != pattern_byte(k)) hit = 1'b0;
        end
        if (hit) begin
          hit_seen   = 1'b1;
          hit_offset = count - n;
        end
      end
      seen_bytes = count;
    end
    if (!is_last) return 1'b0;
    if (hit_seen) res = '{1'b1, hit_offset, base_addr + {32'd0, hit_offset}};
    for (int i = 0; i < PATTERN_BYTES; i++) win[i] = '0;
    seen_bytes = '0;
    hit_seen   = 1'b0;
    hit_offset = '0;
    return 1'b1;
  endfunction

  // Check results first and take new requests after that. A request taken
  // on this edge can never be the one whose result comes out on this edge.
  always @(posedge clk) begin : check_and_predict
    search_result_t want;
    search_result_t got;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.found, out_ch.match_offset, out_ch.match_address};
        if (pending_searches.size() == 0) begin
          $display("%0t: result with no region pending: found %0b offset %0h address %0h",
                   $time, got.found, got.offset, got.address);
          mismatch_count++;
        end else begin
          want = pending_searches.pop_front();
          if (got.found !== want.found) begin
            $display("%0t: found expected %0b, got %0b", $time, want.found, got.found);
            mismatch_count++;
          end
          if (got.offset !== want.offset) begin
            $display("%0t: match_offset expected %0h, got %0h", $time, want.offset,
                     got.offset);
            mismatch_count++;
          end
          if (got.address !== want.address) begin
            $display("%0t: match_address expected %0h, got %0h", $time, want.address,
                     got.address);
            mismatch_count++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        if (search_step(in_ch.data_byte, in_ch.last_byte, want))
          pending_searches.push_back(plan_typed ? plan_result : want);
      end
    end
  end

  // Watchdog: a long run of cycles with no request, result or register write
  // means the block has hung.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_we)
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // Result side. Before each result, stall ready for a random number of
  // cycles. Now and then switch stalling off for a while, so results also
  // come out back to back.
  initial begin : result_ready
    int stall;
    out_ch.ready = 1'b0;
    wait (rst_n);
    @(negedge clk);
    forever begin
      if ($urandom_range(0, 29) == 0) out_idle_on = !out_idle_on;
      stall = out_idle_on ? $urandom_range(0, 19) : 0;
      if (stall > 0) begin
        out_ch.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready = 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      @(negedge clk);
    end
  end

  // Sends one byte request. The task starts and ends on a falling edge, and
  // it leaves valid high so that a byte with no gap follows back to back.
  task automatic send_byte(input logic [7:0] b, input logic is_last, input bit typed,
                           input search_result_t typed_res);
    int gap;
    if ($urandom_range(0, 29) == 0) in_idle_on = !in_idle_on;
    gap = in_idle_on ? $urandom_range(0, 19) : 0;
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid     = 1'b1;
    in_ch.data_byte = b;
    in_ch.last_byte = is_last;
    plan_typed      = typed;
    plan_result     = typed_res;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  // Registers may change only when the block is idle. The task waits for
  // every pending result, then gives the last region time to settle.
  task automatic write_reg(input cfg_reg_t sel, input logic [63:0] value);
    in_ch.valid = 1'b0;
    while (pending_searches.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = sel;
    cfg_data  = value;
    case (sel)
      REG_PATTERN_LENGTH: pat_len      = value[5:0];
      REG_PATTERN_WORD_0: pat_words[0] = value;
      REG_PATTERN_WORD_1: pat_words[1] = value;
      REG_PATTERN_WORD_2: pat_words[2] = value;
      REG_PATTERN_WORD_3: pat_words[3] = value;
      REG_CARE_MASK:      care_bits    = value[31:0];
      REG_BASE_ADDRESS:   base_addr    = value;
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // New pattern setup for a random phase. The first three phases cover the
  // extremes: a full 32 byte exact pattern of all ones at the top address,
  // then a zero length with all zero registers, then a saturated length.
  task automatic setup_phase(input int phase);
    int pick;
    logic [5:0]  len;
    logic [31:0] care;
    logic [63:0] base;
    logic [63:0] word;
    pick = $urandom_range(0, 9);
    if (pick < 6)      len = 6'($urandom_range(1, 8));
    else if (pick < 8) len = 6'($urandom_range(9, PATTERN_BYTES));
    else if (pick == 8) len = 6'd0;
    else               len = 6'($urandom_range(PATTERN_BYTES + 1, 63));
    case ($urandom_range(0, 5))
      0:       care = 32'hFFFF_FFFF;
      1:       care = 32'h0;
      default: care = $urandom;
    endcase
    base = {$urandom, $urandom};
    if (phase == 0) begin
      len  = 6'(PATTERN_BYTES);
      care = 32'hFFFF_FFFF;
      base = 64'hFFFF_FFFF_FFFF_FFFF;
    end else if (phase == 1) begin
      len  = 6'd0;
      care = 32'h0;
      base = 64'h0;
    end else if (phase == 2) begin
      len  = 6'd63;
    end
    write_reg(REG_PATTERN_LENGTH, {58'd0, len});
    for (int w = 0; w < 4; w++) begin
      if (phase == 0)      word = 64'hFFFF_FFFF_FFFF_FFFF;
      else if (phase == 1) word = 64'h0;
      else                 word = {$urandom, $urandom};
      write_reg(cfg_reg_t'(REG_PATTERN_WORD_0 + w), word);
    end
    write_reg(REG_CARE_MASK, {32'd0, care});
    write_reg(REG_BASE_ADDRESS, base);
  endtask

  // One random region. The filler bytes are random, and some of them are
  // taken from the pattern itself. Most regions also get one or two planted
  // copies of the pattern, and now and then the last copy has one bit
  // flipped. A few regions are long, well past the pattern length.
  task automatic send_region();
    logic [7:0] region [$];
    int unsigned n;
    int unsigned size;
    int unsigned pos;
    n = active_len();
    if ($urandom_range(0, 9) < 8) size = $urandom_range(1, n + 12);
    else                          size = $urandom_range(1, 90);
    for (int unsigned i = 0; i < size; i++) begin
      if ($urandom_range(0, 3) == 0) region.push_back(pattern_byte($urandom_range(0, n - 1)));
      else                           region.push_back(8'($urandom));
    end
    if ($urandom_range(0, 9) < 7 && size >= n) begin
      pos = 0;
      repeat ($urandom_range(1, 2)) begin
        pos = $urandom_range(0, size - n);
        for (int unsigned k = 0; k < n; k++) region[pos + k] = pattern_byte(k);
      end
      if ($urandom_range(0, 3) == 0)
        region[pos + $urandom_range(0, n - 1)] ^= 8'(1 << $urandom_range(0, 7));
    end
    for (int unsigned i = 0; i < size; i++) send_byte(region[i], i == size - 1, 1'b0, '0);
    random_bytes += size;
  endtask

  initial begin : stimulus
    int phase;
    int phase_end;
    plan_step_t row;
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = '0;
    cfg_data        = '0;
    in_ch.valid     = 1'b0;
    in_ch.data_byte = '0;
    in_ch.last_byte = 1'b0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    for (int i = 0; i < PLAN_ROWS; i++) begin
      row = directed_plan[i];
      if (row.kind == STEP_REG_WRITE)
        write_reg(row.reg_sel, row.value);
      else
        send_byte(row.data, row.last, row.typed,
                  '{row.exp_found, row.exp_offset, row.exp_address});
    end

    phase = 0;
    while (random_bytes < RANDOM_BYTES) begin
      setup_phase(phase);
      phase++;
      phase_end = random_bytes + $urandom_range(80, 220);
      while (random_bytes < phase_end && random_bytes < RANDOM_BYTES) send_region();
    end

    in_ch.valid = 1'b0;
    while (pending_searches.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatch_count == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule

FILE: masked_byte_pattern_search.f
design/mbps_pkg.sv
design/mbps_if.sv
design/mbps_front.sv
design/mbps_queue.sv
design/mbps_back.sv
design/masked_byte_pattern_search.sv
design/mbps_checker.sv
dv/tb_top.sv
